### sv/mrtu_pkg.sv
// Shared types, register map, Modbus codes and CRC-16 helper for the RTU slave.
// No dependencies; used by every module of the block.
package mrtu_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } tx_word_t;

  localparam int DEF_FRAME_BYTES = 64;
  localparam int DEF_REG_COUNT   = 16;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SLAVE_ID    = 3'd0;
  localparam logic [2:0] REG_READ_FIRST  = 3'd1;
  localparam logic [2:0] REG_READ_END    = 3'd2;
  localparam logic [2:0] REG_WRITE_FIRST = 3'd3;
  localparam logic [2:0] REG_WRITE_END   = 3'd4;

  // function codes
  localparam logic [7:0] FC_READ_HOLD  = 8'h03;
  localparam logic [7:0] FC_WRITE_ONE  = 8'h06;
  localparam logic [7:0] FC_WRITE_MULT = 8'h10;
  localparam logic [7:0] FC_MASK_WRITE = 8'h16;
  localparam logic [7:0] FC_READ_WRITE = 8'h17;
  localparam logic [7:0] FC_EXC_FLAG   = 8'h80;

  // exception codes
  localparam logic [7:0] EXC_FUNCTION = 8'h01;
  localparam logic [7:0] EXC_ADDRESS  = 8'h02;
  localparam logic [7:0] EXC_VALUE    = 8'h03;

  localparam logic [16:0] QTY_READ_MAX  = 17'h0007D;
  localparam logic [16:0] QTY_WMULT_MAX = 17'h0007B;
  localparam logic [16:0] QTY_RW_MAX    = 17'h00079;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int n = 0; n < 8; n++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### sv/mrtu_hold_mem.sv
// Holding-register store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses mrtu_pkg.
module mrtu_hold_mem #(
  parameter int REG_COUNT = mrtu_pkg::DEF_REG_COUNT,
  parameter int IDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [15:0]      wdata,
  input  logic [IDX_W-1:0] raddr,
  output logic [15:0]      rdata
);

  logic [15:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // read with write forwarding
  always_ff @(posedge clk) begin
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else if (valid[raddr]) begin
      rdata <= mem[raddr];
    end else begin
      rdata <= '0;
    end
  end

endmodule

### sv/modbus_rtu_slave_frame_engine.sv
// Modbus RTU slave frame engine: frame buffer, CRC check, request sequencer.
// Depends on mrtu_pkg and mrtu_hold_mem.
//
// Usage:
//  - Received bytes enter on rx (rx_byte, frame_end) when start is high and
//    busy is low. Between frames one byte is taken per cycle; each is folded
//    into the running CRC-16 and, while room is left, into the frame buffer.
//  - On the byte with frame_end set the frame is judged (length >= 4, no
//    overflow, CRC residue zero, id match). A dropped frame leaves busy low.
//  - A good frame raises busy: S_HDR fetches the header bytes from the frame
//    buffer, S_DEC1 and S_DEC2 decide, then for multiple writes each written
//    register byte passes S_WR_REQ and S_WR_GET (one frame buffer read port),
//    then the response streams out one word per cycle, except read data, which
//    passes S_RD_REQ, S_RD_HI, S_RD_LO per register (one holding store read each).
//  - Each response word is shown on tx with tx_valid high for exactly one
//    cycle; the receiver cannot stall. tx_last marks the CRC high byte.
//  - Config registers sit on the APB port at 4*index; pready is always high.
//    Write them only while busy is low.
//  - Synchronous reset: config returns to defaults, the holding store reads
//    as zero, the frame state clears; no clearing pass is needed.
module modbus_rtu_slave_frame_engine #(
  parameter int FRAME_BYTES = mrtu_pkg::DEF_FRAME_BYTES,
  parameter int REG_COUNT   = mrtu_pkg::DEF_REG_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mrtu_pkg::rx_word_t rx,
  output logic               tx_valid,
  output mrtu_pkg::tx_word_t tx,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int FA_W  = $clog2(FRAME_BYTES);
  localparam int LEN_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [16:0] REG_COUNT_17 = 17'(REG_COUNT);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_HDR    = 4'd1;
  localparam logic [3:0] S_DEC1   = 4'd2;
  localparam logic [3:0] S_DEC2   = 4'd3;
  localparam logic [3:0] S_WR_REQ = 4'd4;
  localparam logic [3:0] S_WR_GET = 4'd5;
  localparam logic [3:0] S_EMIT   = 4'd6;
  localparam logic [3:0] S_RD_REQ = 4'd7;
  localparam logic [3:0] S_RD_HI  = 4'd8;
  localparam logic [3:0] S_RD_LO  = 4'd9;
  localparam logic [3:0] S_CRC_LO = 4'd10;
  localparam logic [3:0] S_CRC_HI = 4'd11;

  // ---------------- configuration ----------------
  logic [7:0]  slave_id;
  logic [15:0] read_first, read_end, write_first, write_end;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_id    <= 8'd1;
      read_first  <= 16'd0;
      read_end    <= 16'd16;
      write_first <= 16'd0;
      write_end   <= 16'd15;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        mrtu_pkg::REG_SLAVE_ID:    slave_id    <= pwdata[7:0];
        mrtu_pkg::REG_READ_FIRST:  read_first  <= pwdata[15:0];
        mrtu_pkg::REG_READ_END:    read_end    <= pwdata[15:0];
        mrtu_pkg::REG_WRITE_FIRST: write_first <= pwdata[15:0];
        mrtu_pkg::REG_WRITE_END:   write_end   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      mrtu_pkg::REG_SLAVE_ID:    prdata = {24'd0, slave_id};
      mrtu_pkg::REG_READ_FIRST:  prdata = {16'd0, read_first};
      mrtu_pkg::REG_READ_END:    prdata = {16'd0, read_end};
      mrtu_pkg::REG_WRITE_FIRST: prdata = {16'd0, write_first};
      mrtu_pkg::REG_WRITE_END:   prdata = {16'd0, write_end};
      default:                   prdata = '0;
    endcase
  end

  // ---------------- state ----------------
  logic [3:0]       state;
  logic [LEN_W-1:0] frame_length;
  logic             frame_overflow;
  logic [15:0]      running_crc;
  logic [7:0]       byte0;
  logic [LEN_W-1:0] plen;            // payload length (frame minus CRC)

  logic [7:0]       frame_mem [FRAME_BYTES];
  logic [FA_W-1:0]  faddr;
  logic [7:0]       fdata;

  logic [7:0]       hdr [11];
  logic [3:0]       hcnt;

  // decode flags, registered in DEC1
  logic q_rd_ok, q16_ok, q23_ok, rd_ok, wm_ok, ws_ok;
  logic [IDX_W-1:0] rbase, wbase;

  // sequencing
  logic [8:0]       p;               // frame byte pointer for write data
  logic             phase_lo;
  logic [7:0]       hi_byte;
  logic [6:0]       wcnt, ridx;
  logic [6:0]       wq_r, q_r;
  logic             after_rd;        // emit prefix then read data
  logic [7:0]       ebuf [6];
  logic [2:0]       ecnt, elen;
  logic [15:0]      tx_crc;
  logic [7:0]       crc_hi;
  logic [15:0]      rword;

  // holding store interface
  logic             h_we;
  logic [IDX_W-1:0] h_waddr, h_raddr;
  logic [15:0]      h_wdata, h_rdata;

  mrtu_hold_mem #(
    .REG_COUNT (REG_COUNT),
    .IDX_W     (IDX_W)
  ) u_hold (
    .clk   (clk),
    .rst   (rst),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  assign busy = (state != S_IDLE);

  // accept path
  logic             accept;
  logic [15:0]      crc_next;
  logic [LEN_W-1:0] len_next;
  logic             ovf_next, room, good;
  logic [7:0]       b0_eff;

  assign accept   = start && !busy;
  assign room     = (frame_length < LEN_W'(FRAME_BYTES));
  assign crc_next = mrtu_pkg::crc_byte(running_crc, rx.rx_byte);
  assign len_next = room ? frame_length + 1'b1 : frame_length;
  assign ovf_next = frame_overflow || !room;
  assign b0_eff   = (frame_length == '0) ? rx.rx_byte : byte0;
  assign good     = !ovf_next && (len_next >= LEN_W'(4)) && (crc_next == 16'd0) &&
                    (b0_eff == slave_id);

  always_ff @(posedge clk) begin
    if (accept && room) begin
      frame_mem[frame_length[FA_W-1:0]] <= rx.rx_byte;
    end
    fdata <= frame_mem[faddr];
  end

  assign faddr = (state == S_HDR) ? FA_W'(hcnt) : p[FA_W-1:0];

  // header field views
  logic [7:0]  fc;
  logic [16:0] a, q, wa, wq, ws, wqt;
  assign fc  = hdr[1];
  assign a   = {1'b0, hdr[2], hdr[3]};
  assign q   = {1'b0, hdr[4], hdr[5]};
  assign wa  = {1'b0, hdr[6], hdr[7]};
  assign wq  = {1'b0, hdr[8], hdr[9]};
  assign ws  = (fc == mrtu_pkg::FC_READ_WRITE) ? wa : a;
  assign wqt = (fc == mrtu_pkg::FC_READ_WRITE) ? wq : q;

  // byte fetched during write-data phase, zero beyond the payload
  logic [7:0] wr_byte;
  assign wr_byte = (p < 9'(plen)) ? fdata : 8'd0;

  // request decode: response prefix, length and next step
  logic [3:0] dec_state;
  logic [2:0] dec_elen;
  logic [7:0] dec_b1, dec_b2;
  logic       dec_echo, dec_after_rd;
  logic [8:0] dec_p;

  always_comb begin
    dec_state    = S_EMIT;
    dec_elen     = 3'd3;
    dec_b1       = fc | mrtu_pkg::FC_EXC_FLAG;
    dec_b2       = mrtu_pkg::EXC_FUNCTION;
    dec_echo     = 1'b0;
    dec_after_rd = 1'b0;
    dec_p        = p;
    case (fc)
      mrtu_pkg::FC_READ_HOLD: begin
        if (!q_rd_ok) begin
          dec_b2 = mrtu_pkg::EXC_VALUE;
        end else if (!rd_ok) begin
          dec_b2 = mrtu_pkg::EXC_ADDRESS;
        end else begin
          dec_b1       = fc;
          dec_b2       = {q_r, 1'b0};
          dec_after_rd = 1'b1;
        end
      end
      mrtu_pkg::FC_WRITE_ONE: begin
        if (!ws_ok) begin
          dec_b2 = mrtu_pkg::EXC_ADDRESS;
        end else begin
          dec_echo = 1'b1;
          dec_elen = 3'd6;
        end
      end
      mrtu_pkg::FC_WRITE_MULT: begin
        if (!q16_ok) begin
          dec_b2 = mrtu_pkg::EXC_VALUE;
        end else if (!wm_ok) begin
          dec_b2 = mrtu_pkg::EXC_ADDRESS;
        end else begin
          dec_echo  = 1'b1;
          dec_elen  = 3'd6;
          dec_p     = 9'd7;
          dec_state = S_WR_REQ;
        end
      end
      mrtu_pkg::FC_READ_WRITE: begin
        if (!(q23_ok && q_rd_ok)) begin
          dec_b2 = mrtu_pkg::EXC_VALUE;
        end else if (!(wm_ok && rd_ok)) begin
          dec_b2 = mrtu_pkg::EXC_ADDRESS;
        end else begin
          dec_b1       = fc;
          dec_b2       = {q_r, 1'b0};
          dec_after_rd = 1'b1;
          dec_p        = 9'd11;
          dec_state    = S_WR_REQ;
        end
      end
      mrtu_pkg::FC_MASK_WRITE: dec_state = S_IDLE;
      default: ;
    endcase
  end

  // holding store ports
  always_comb begin
    h_we    = 1'b0;
    h_waddr = wbase;
    h_wdata = {hi_byte, wr_byte};
    if (state == S_DEC2 && fc == mrtu_pkg::FC_WRITE_ONE && ws_ok) begin
      h_we    = 1'b1;
      h_waddr = wbase;
      h_wdata = q[15:0];
    end else if (state == S_WR_GET && phase_lo) begin
      h_we    = 1'b1;
      h_waddr = IDX_W'(wbase + IDX_W'(wcnt));
    end
  end
  assign h_raddr = IDX_W'(rbase + IDX_W'(ridx));

  // response byte source
  logic       emit_en, emit_last;
  logic [7:0] emit_b;
  always_comb begin
    emit_en   = 1'b0;
    emit_last = 1'b0;
    emit_b    = ebuf[ecnt];
    case (state)
      S_EMIT:   emit_en = 1'b1;
      S_RD_HI: begin
        emit_en = 1'b1;
        emit_b  = h_rdata[15:8];
      end
      S_RD_LO: begin
        emit_en = 1'b1;
        emit_b  = rword[7:0];
      end
      S_CRC_LO: begin
        emit_en = 1'b1;
        emit_b  = tx_crc[7:0];
      end
      S_CRC_HI: begin
        emit_en   = 1'b1;
        emit_b    = crc_hi;
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else begin
      tx_valid <= emit_en;
    end
    if (emit_en) begin
      tx.tx_byte <= emit_b;
      tx.tx_last <= emit_last;
      tx_crc     <= mrtu_pkg::crc_byte(tx_crc, emit_b);
    end
    if (state == S_DEC2) begin
      tx_crc <= mrtu_pkg::CRC_INIT;
    end
    if (state == S_CRC_LO) begin
      crc_hi <= tx_crc[15:8];
    end
    if (state == S_RD_HI) begin
      rword <= h_rdata;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      frame_length   <= '0;
      frame_overflow <= 1'b0;
      running_crc    <= mrtu_pkg::CRC_INIT;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (frame_length == '0) begin
              byte0 <= rx.rx_byte;
            end
            if (rx.frame_end) begin
              frame_length   <= '0;
              frame_overflow <= 1'b0;
              running_crc    <= mrtu_pkg::CRC_INIT;
              if (good) begin
                plen  <= LEN_W'(len_next - LEN_W'(2));
                hcnt  <= 4'd0;
                state <= S_HDR;
              end
            end else begin
              frame_length   <= len_next;
              frame_overflow <= ovf_next;
              running_crc    <= crc_next;
            end
          end
        end
        S_HDR: begin
          if (hcnt != 4'd0) begin
            hdr[hcnt - 4'd1] <= (LEN_W'(hcnt - 4'd1) < plen) ? fdata : 8'd0;
          end
          hcnt <= hcnt + 4'd1;
          if (hcnt == 4'd11) begin
            state <= S_DEC1;
          end
        end
        S_DEC1: begin
          q_rd_ok <= (q >= 17'd1) && (q <= mrtu_pkg::QTY_READ_MAX);
          q16_ok  <= (q >= 17'd1) && (q <= mrtu_pkg::QTY_WMULT_MAX) &&
                     ({9'd0, hdr[6]} == {q[15:0], 1'b0});
          q23_ok  <= (wq >= 17'd1) && (wq <= mrtu_pkg::QTY_RW_MAX) &&
                     ({9'd0, hdr[10]} == {wq[15:0], 1'b0});
          rd_ok   <= (a >= {1'b0, read_first}) && (a + q <= {1'b0, read_end}) &&
                     ((a - {1'b0, read_first}) + q <= REG_COUNT_17);
          wm_ok   <= (ws >= {1'b0, write_first}) && (ws + wqt <= {1'b0, write_end}) &&
                     ((ws - {1'b0, write_first}) + wqt <= REG_COUNT_17);
          ws_ok   <= (a >= {1'b0, write_first}) && (a <= {1'b0, write_end}) &&
                     ((a - {1'b0, write_first}) < REG_COUNT_17);
          rbase   <= IDX_W'(a - {1'b0, read_first});
          wbase   <= IDX_W'(ws - {1'b0, write_first});
          wq_r    <= wqt[6:0];
          q_r     <= q[6:0];
          state   <= S_DEC2;
        end
        S_DEC2: begin
          ecnt     <= 3'd0;
          wcnt     <= 7'd0;
          ridx     <= 7'd0;
          phase_lo <= 1'b0;
          after_rd <= dec_after_rd;
          ebuf[0]  <= hdr[0];
          ebuf[1]  <= dec_echo ? hdr[1] : dec_b1;
          ebuf[2]  <= dec_echo ? hdr[2] : dec_b2;
          for (int i = 3; i < 6; i++) ebuf[i] <= hdr[i];
          elen     <= dec_elen;
          p        <= dec_p;
          state    <= dec_state;
        end
        S_WR_REQ: state <= S_WR_GET;
        S_WR_GET: begin
          p        <= p + 9'd1;
          phase_lo <= !phase_lo;
          if (!phase_lo) begin
            hi_byte <= wr_byte;
            state   <= S_WR_REQ;
          end else begin
            wcnt <= wcnt + 7'd1;
            state <= (wcnt + 7'd1 == wq_r) ? S_EMIT : S_WR_REQ;
          end
        end
        S_EMIT: begin
          ecnt <= ecnt + 3'd1;
          if (ecnt + 3'd1 == elen) begin
            state <= after_rd ? S_RD_REQ : S_CRC_LO;
          end
        end
        S_RD_REQ: state <= S_RD_HI;
        S_RD_HI:  state <= S_RD_LO;
        S_RD_LO: begin
          ridx  <= ridx + 7'd1;
          state <= (ridx + 7'd1 == q_r) ? S_CRC_LO : S_RD_REQ;
        end
        S_CRC_LO: state <= S_CRC_HI;
        S_CRC_HI: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_no_tx_from_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> !tx_valid)
    else $error("response word emitted while idle");

  a_more_after_mid: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && !tx.tx_last) |-> busy)
    else $error("response ended without a last word");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    frame_length <= LEN_W'(FRAME_BYTES))
    else $error("frame length beyond buffer");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && tx.tx_last) |-> !busy)
    else $error("busy after final response word");

endmodule

### tb/tb_modbus_rtu_slave_frame_engine.sv
// Self-checking testbench for modbus_rtu_slave_frame_engine: drives request frames,
// predicts every response word and compares it. Depends on mrtu_pkg and the block RTL.
module tb_modbus_rtu_slave_frame_engine;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  mrtu_pkg::rx_word_t rx = '0;
  logic               tx_valid;
  mrtu_pkg::tx_word_t tx;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  modbus_rtu_slave_frame_engine i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .rx(rx),
    .tx_valid(tx_valid), .tx(tx), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------
  // Slave model: config copy, frame buffer, running CRC, holding store
  // ---------------------------------------------------------------
  int unsigned        cfg_id, cfg_rfirst, cfg_rend, cfg_wfirst, cfg_wend;
  logic [7:0]         frm_buf[64];
  int unsigned        frm_len;
  bit                 frm_ovf;
  logic [15:0]        frm_crc;
  logic [15:0]        hold_regs[16];
  int unsigned        pay_len;
  logic [7:0]         rsp_bytes[$];
  mrtu_pkg::tx_word_t expected_words[$];

  int errors = 0;
  int words_seen = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int gap_pct = 0;

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int n = 0; n < 8; n++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  // request byte i, zero past the payload
  function automatic int unsigned req_byte(int unsigned i);
    return (i < pay_len && i < 64) ? frm_buf[i] : 0;
  endfunction

  function automatic int unsigned req_word(int unsigned i);
    return (req_byte(i) << 8) | req_byte(i + 1);
  endfunction

  function automatic bit read_window_ok(int unsigned s, int unsigned q);
    return s >= cfg_rfirst && s + q <= cfg_rend && (s - cfg_rfirst) + q <= 16;
  endfunction

  function automatic bit write_window_ok(int unsigned s, int unsigned q);
    return s >= cfg_wfirst && s + q <= cfg_wend && (s - cfg_wfirst) + q <= 16;
  endfunction

  task automatic add_exception(int unsigned fc, logic [7:0] code);
    rsp_bytes = {};
    rsp_bytes.push_back(8'(req_byte(0)));
    rsp_bytes.push_back(8'(fc) | mrtu_pkg::FC_EXC_FLAG);
    rsp_bytes.push_back(code);
  endtask

  task automatic add_read_data(int unsigned fc, int unsigned s, int unsigned q);
    int unsigned base;
    base = s - cfg_rfirst;
    rsp_bytes.push_back(8'(req_byte(0)));
    rsp_bytes.push_back(8'(fc));
    rsp_bytes.push_back(8'(q * 2));
    for (int unsigned i = 0; i < q && base + i < 16; i++) begin
      rsp_bytes.push_back(hold_regs[base + i][15:8]);
      rsp_bytes.push_back(hold_regs[base + i][7:0]);
    end
  endtask

  task automatic store_regs(int unsigned s, int unsigned q, int unsigned at);
    int unsigned base;
    base = s - cfg_wfirst;
    for (int unsigned i = 0; i < q && base + i < 16; i++)
      hold_regs[base + i] = 16'(req_word(at + 2 * i));
  endtask

  task automatic echo_header();
    for (int unsigned i = 0; i < 6; i++) rsp_bytes.push_back(8'(req_byte(i)));
  endtask

  // decode one accepted frame into rsp_bytes
  task automatic serve_request();
    int unsigned fc, a, q, wa, wq;
    fc = req_byte(1);
    a  = req_word(2);
    q  = req_word(4);
    rsp_bytes = {};
    if (fc == mrtu_pkg::FC_READ_HOLD) begin
      if (q < 1 || q > mrtu_pkg::QTY_READ_MAX) add_exception(fc, mrtu_pkg::EXC_VALUE);
      else if (!read_window_ok(a, q)) add_exception(fc, mrtu_pkg::EXC_ADDRESS);
      else add_read_data(fc, a, q);
    end else if (fc == mrtu_pkg::FC_WRITE_ONE) begin
      if (!(a >= cfg_wfirst && a <= cfg_wend && a - cfg_wfirst < 16)) begin
        add_exception(fc, mrtu_pkg::EXC_ADDRESS);
      end else begin
        hold_regs[a - cfg_wfirst] = 16'(q);
        echo_header();
      end
    end else if (fc == mrtu_pkg::FC_WRITE_MULT) begin
      if (q < 1 || q > mrtu_pkg::QTY_WMULT_MAX || req_byte(6) != q * 2)
        add_exception(fc, mrtu_pkg::EXC_VALUE);
      else if (!write_window_ok(a, q)) add_exception(fc, mrtu_pkg::EXC_ADDRESS);
      else begin
        store_regs(a, q, 7);
        echo_header();
      end
    end else if (fc == mrtu_pkg::FC_READ_WRITE) begin
      wa = req_word(6);
      wq = req_word(8);
      if (wq < 1 || wq > mrtu_pkg::QTY_RW_MAX || req_byte(10) != wq * 2 || q < 1 ||
          q > mrtu_pkg::QTY_READ_MAX)
        add_exception(fc, mrtu_pkg::EXC_VALUE);
      else if (!write_window_ok(wa, wq) || !read_window_ok(a, q))
        add_exception(fc, mrtu_pkg::EXC_ADDRESS);
      else begin
        store_regs(wa, wq, 11);   // writes land before the read
        add_read_data(fc, a, q);
      end
    end else if (fc != mrtu_pkg::FC_MASK_WRITE) begin
      add_exception(fc, mrtu_pkg::EXC_FUNCTION);
    end
  endtask

  // fold one accepted word into the model; queue the response words
  task automatic model_rx_word(logic [7:0] b, bit last);
    logic [15:0] c;
    mrtu_pkg::tx_word_t w;
    if (frm_len < 64) begin
      frm_buf[frm_len] = b;
      frm_len++;
    end else begin
      frm_ovf = 1'b1;
    end
    frm_crc = crc_step(frm_crc, b);
    if (!last) return;
    if (!frm_ovf && frm_len >= 4 && frm_crc == 16'h0000 && frm_buf[0] == cfg_id) begin
      pay_len = frm_len - 2;
      serve_request();
      if (rsp_bytes.size() > 0) begin
        c = mrtu_pkg::CRC_INIT;
        foreach (rsp_bytes[i]) c = crc_step(c, rsp_bytes[i]);
        rsp_bytes.push_back(c[7:0]);
        rsp_bytes.push_back(c[15:8]);
        foreach (rsp_bytes[i]) begin
          w.tx_byte = rsp_bytes[i];
          w.tx_last = (i == rsp_bytes.size() - 1);
          expected_words.push_back(w);
        end
      end
    end
    frm_len = 0;
    frm_ovf = 1'b0;
    frm_crc = mrtu_pkg::CRC_INIT;
  endtask

  // ---------------------------------------------------------------
  // Response checker: each response word lasts one cycle, sampled mid-cycle
  // ---------------------------------------------------------------
  always @(negedge clk) begin
    mrtu_pkg::tx_word_t e;
    if (!rst && tx_valid) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected response word byte=%02h last=%0b", $time, tx.tx_byte,
                 tx.tx_last);
      end else begin
        e = expected_words.pop_front();
        if (tx.tx_byte !== e.tx_byte) begin
          errors++;
          $display("%0t: tx_byte expected %02h actual %02h", $time, e.tx_byte, tx.tx_byte);
        end
        if (tx.tx_last !== e.tx_last) begin
          errors++;
          $display("%0t: tx_last expected %0b actual %0b", $time, e.tx_last, tx.tx_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------
  // called just after a rising edge; returns just after the accepting edge,
  // or after the idle cycles that follow it (each cycle idle with gap_pct odds)
  task automatic send_word(logic [7:0] b, bit last);
    bit taken;
    start <= 1'b1;
    rx <= '{rx_byte: b, frame_end: last};
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    model_rx_word(b, last);
    bytes_sent++;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // pdu plus CRC (low byte first); bad_crc flips one CRC bit
  task automatic send_frame(logic [7:0] pdu[$], bit bad_crc = 1'b0);
    logic [15:0] c;
    c = mrtu_pkg::CRC_INIT;
    foreach (pdu[i]) c = crc_step(c, pdu[i]);
    if (bad_crc) c[$urandom_range(15)] ^= 1'b1;
    pdu.push_back(c[7:0]);
    pdu.push_back(c[15:8]);
    foreach (pdu[i]) send_word(pdu[i], i == pdu.size() - 1);
    frames_sent++;
  endtask

  // raw bytes, no CRC appended
  task automatic send_raw(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_word(bytes[i], i == bytes.size() - 1);
    frames_sent++;
  endtask

  // let all responses drain and the sequencer go idle
  task automatic wait_idle();
    bit idle;
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    do begin
      @(negedge clk);
      idle = !busy;
      @(posedge clk);
    end while (!idle);
  endtask

  task automatic reg_write(logic [2:0] idx, int unsigned val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      mrtu_pkg::REG_SLAVE_ID:    cfg_id = val & 8'hFF;
      mrtu_pkg::REG_READ_FIRST:  cfg_rfirst = val & 16'hFFFF;
      mrtu_pkg::REG_READ_END:    cfg_rend = val & 16'hFFFF;
      mrtu_pkg::REG_WRITE_FIRST: cfg_wfirst = val & 16'hFFFF;
      default:                   cfg_wend = val & 16'hFFFF;
    endcase
  endtask

  task automatic set_windows(int unsigned id, int unsigned rf, int unsigned re,
                             int unsigned wf, int unsigned we);
    wait_idle();
    reg_write(mrtu_pkg::REG_SLAVE_ID, id);
    reg_write(mrtu_pkg::REG_READ_FIRST, rf);
    reg_write(mrtu_pkg::REG_READ_END, re);
    reg_write(mrtu_pkg::REG_WRITE_FIRST, wf);
    reg_write(mrtu_pkg::REG_WRITE_END, we);
  endtask

  // ---------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------
  function automatic void put16(ref logic [7:0] q[$], int unsigned v);
    q.push_back(8'(v >> 8));
    q.push_back(8'(v));
  endfunction

  task automatic read_req(int unsigned a, int unsigned n);
    logic [7:0] p[$];
    p = {8'(cfg_id), mrtu_pkg::FC_READ_HOLD};
    put16(p, a);
    put16(p, n);
    send_frame(p);
  endtask

  task automatic write_one_req(int unsigned a, int unsigned v);
    logic [7:0] p[$];
    p = {8'(cfg_id), mrtu_pkg::FC_WRITE_ONE};
    put16(p, a);
    put16(p, v);
    send_frame(p);
  endtask

  // at most 8 data bytes go out; the rest read as zero
  task automatic write_mult_req(int unsigned a, int unsigned n, int unsigned cnt);
    logic [7:0] p[$];
    p = {8'(cfg_id), mrtu_pkg::FC_WRITE_MULT};
    put16(p, a);
    put16(p, n);
    p.push_back(8'(cnt));
    for (int i = 0; i < cnt && i < 8; i++) p.push_back(8'($urandom));
    send_frame(p);
  endtask

  task automatic read_write_req(int unsigned ra, int unsigned rn, int unsigned wa,
                                int unsigned wn, int unsigned cnt);
    logic [7:0] p[$];
    p = {8'(cfg_id), mrtu_pkg::FC_READ_WRITE};
    put16(p, ra);
    put16(p, rn);
    put16(p, wa);
    put16(p, wn);
    p.push_back(8'(cnt));
    for (int i = 0; i < cnt && i < 8; i++) p.push_back(8'($urandom));
    send_frame(p);
  endtask

  // address near the window most of the time, anywhere otherwise
  function automatic int unsigned pick_addr(int unsigned first);
    if ($urandom_range(9) < 8) return first + $urandom_range(0, 18);
    return $urandom_range(0, 65535);
  endfunction

  function automatic int unsigned pick_qty(int unsigned cap);
    if ($urandom_range(9) < 8) return $urandom_range(1, 17);
    return $urandom_range(0, cap + 3);
  endfunction

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_directed();
    logic [7:0] p[$];
    read_req(0, 16);                       // store reads zero after reset
    write_one_req(0, 16'hFFFF);
    write_mult_req(0, 15, 30);             // reaches write_end exactly
    read_req(0, 16);
    read_write_req(0, 4, 3, 2, 4);         // write lands before the read
    p = {8'(cfg_id), mrtu_pkg::FC_MASK_WRITE, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'hFF};
    send_frame(p);                         // mask write: silent
    p = {8'(cfg_id), 8'h2B, 8'h0E};
    send_frame(p);                         // unsupported function
    p = {8'(cfg_id), mrtu_pkg::FC_READ_HOLD};
    send_frame(p);                         // header fields missing, read as zero
    p = {8'(cfg_id), mrtu_pkg::FC_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'h01};
    send_frame(p, 1'b1);                   // CRC error: dropped
    send_raw({8'(cfg_id), mrtu_pkg::FC_READ_HOLD, 8'h00});   // short frame
    p = {};
    for (int i = 0; i < 63; i++) p.push_back(8'($urandom));
    p[0] = 8'(cfg_id);
    p[1] = mrtu_pkg::FC_WRITE_ONE;
    send_frame(p);                         // one byte past the buffer: dropped
  endtask

  task automatic test_random(int n_bytes);
    logic [7:0] p[$];
    int stop_at;
    int unsigned n, kind;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 22) read_req(pick_addr(cfg_rfirst), pick_qty(125));
      else if (kind < 42) write_one_req(pick_addr(cfg_wfirst), $urandom_range(0, 65535));
      else if (kind < 60) begin
        n = pick_qty(123);
        write_mult_req(pick_addr(cfg_wfirst), n,
                       ($urandom_range(9) < 8) ? (2 * n) & 8'hFF : $urandom_range(0, 40));
      end else if (kind < 78) begin
        n = pick_qty(121);
        read_write_req(pick_addr(cfg_rfirst), pick_qty(125), pick_addr(cfg_wfirst), n,
                       ($urandom_range(9) < 8) ? (2 * n) & 8'hFF : $urandom_range(0, 40));
      end else if (kind < 84) begin
        p = {8'(cfg_id), 8'($urandom)};
        repeat ($urandom_range(0, 6)) p.push_back(8'($urandom));
        send_frame(p);                     // arbitrary function code and payload
      end else if (kind < 90) begin
        p = {8'(cfg_id), mrtu_pkg::FC_READ_HOLD, 8'($urandom), 8'($urandom), 8'h00, 8'h02};
        send_frame(p, 1'b1);
      end else if (kind < 95) begin
        p = {8'($urandom), mrtu_pkg::FC_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'h01};
        send_frame(p);                     // id most likely foreign
      end else begin
        p = {};
        repeat ($urandom_range(1, 12)) p.push_back(8'($urandom));
        send_raw(p);                       // noise
      end
    end
  endtask

  // several window settings, extremes among them
  task automatic test_windows();
    set_windows(247, 100, 116, 100, 115);
    test_random(5);
    set_windows(0, 65520, 65535, 65530, 65535);
    read_req(65520, 15);
    write_one_req(65535, 16'hA5A5);
    test_random(5);
    set_windows(1, 0, 0, 0, 0);            // nothing readable, entry 0 writable
    write_one_req(0, 16'h5A5A);
    test_random(5);
    set_windows(1, 0, 16, 0, 15);
  endtask

  initial begin
    cfg_id = 1;
    cfg_rfirst = 0;
    cfg_rend = 16;
    cfg_wfirst = 0;
    cfg_wend = 15;
    frm_len = 0;
    frm_ovf = 1'b0;
    frm_crc = mrtu_pkg::CRC_INIT;
    foreach (hold_regs[i]) hold_regs[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct = 0;
    test_directed();
    gap_pct = 79;
    test_random(20);
    gap_pct = 0;
    test_random(10);
    gap_pct = 8;
    test_windows();

    wait_idle();
    repeat (50) @(posedge clk);
    $display("covered %0d frames (%0d bytes), %0d response words checked",
             frames_sent, bytes_sent, words_seen);
    $display("every function code, exceptions, dropped frames and several windows");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d words never seen", errors, expected_words.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(8 * 2000000);
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
